>>> hw/rtl/me_pkg.sv
// Shared constants for the modular exponentiation block.
package me_pkg;

  localparam int BASE_WIDTH             = 63;
  localparam int EXPONENT_WIDTH_DEFAULT = 63;
  localparam int MODULUS_WIDTH_DEFAULT  = 31;
  localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

endpackage

>>> hw/rtl/me_mulmod.sv
// Bit-serial modular multiplier: r = x * y mod m, one bit of x per cycle.
module me_mulmod import me_pkg::*; #(
  parameter int XW = BASE_WIDTH,
  parameter int MW = MODULUS_WIDTH_DEFAULT,
  localparam int CW = $clog2(XW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [XW-1:0] x,      // multiplier bits, msb first, left aligned
  input  logic [CW-1:0] nbits,  // number of bits of x to use, at least one
  input  logic [MW-1:0] y,      // must be below m
  input  logic [MW-1:0] m,      // nonzero
  output logic          busy,
  output logic          done,
  output logic [MW-1:0] r
);

  logic [XW-1:0] xs;
  logic [CW-1:0] cnt;
  logic [MW+1:0] mm;
  logic [MW+1:0] t;
  logic [MW+1:0] t1;
  logic [MW+1:0] t2;

  // 2r + y < 3m, so at most two subtractions
  assign mm = {2'b00, m};
  assign t  = {1'b0, r, 1'b0} + (xs[XW-1] ? {2'b00, y} : '0);
  assign t1 = (t >= mm) ? t - mm : t;
  assign t2 = (t1 >= mm) ? t1 - mm : t1;

  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= x;
      cnt <= nbits;
      r   <= '0;
    end else if (busy) begin
      xs  <= xs << 1;
      cnt <= cnt - 1'b1;
      r   <= t2[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  a_residue_reduced: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(start) |-> r < m)
    else $error("partial product not reduced");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    busy && !start && cnt == CW'(1) |=> done && !busy)
    else $error("done missing after last bit");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy || $past(start))
    else $error("done while still working");

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Modular exponentiation top level: square-and-multiply sequencer around a shared multiplier.
//
// Computes base ** exponent mod modulus for each request and returns one
// result. The modulus register (reset 1000000007) is written through the cfg
// channel; the user must write it only while the block is idle, and the block
// itself does not enforce this. A zero modulus gives a result of 0. The block
// takes one request at a time. All arithmetic runs through one bit-serial
// modular multiplier that handles one multiplier bit per cycle: first the
// base is reduced, then every exponent bit costs a squaring and, for a one
// bit, a multiplication. A finished result waits in the output register
// while the next request is taken.
module modular_exponentiation import me_pkg::*; #(
  parameter int EXPONENT_WIDTH = EXPONENT_WIDTH_DEFAULT,
  parameter int MODULUS_WIDTH  = MODULUS_WIDTH_DEFAULT,
  localparam int IN_W  = ((BASE_WIDTH + EXPONENT_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((MODULUS_WIDTH + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MODULUS_WIDTH-1:0] cfg_data,       // modulus
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_W-1:0]          s_axis_tdata,   // base, exponent, zero fill
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_W-1:0]         m_axis_tdata    // power_mod, zero fill
);

  localparam int MW = MODULUS_WIDTH;
  localparam int EW = EXPONENT_WIDTH;
  localparam int CW = $clog2(BASE_WIDTH + 1);
  localparam int BW = $clog2(EW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_SQR,
    S_MUL,
    S_OUT
  } state_t;

  state_t                  state;
  logic [MW-1:0]           modulus;
  logic [MW-1:0]           one_mod;
  logic [EW-1:0]           ex;
  logic [BW-1:0]           bits_left;
  logic [MW-1:0]           acc;
  logic [MW-1:0]           breg;
  logic                    kick;
  logic [BASE_WIDTH-1:0]   op_x;
  logic [CW-1:0]           op_n;
  logic [MW-1:0]           op_y;
  logic                    mm_busy;
  logic                    mm_done;
  logic [MW-1:0]           mm_r;
  logic                    accept;
  logic                    last_bit;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign one_mod       = (modulus == MW'(1)) ? '0 : MW'(1);
  assign last_bit      = (bits_left == BW'(1));

  me_mulmod #(
    .XW (BASE_WIDTH),
    .MW (MW)
  ) u_mulmod (
    .clk   (clk),
    .rst   (rst),
    .start (kick),
    .x     (op_x),
    .nbits (op_n),
    .y     (op_y),
    .m     (modulus),
    .busy  (mm_busy),
    .done  (mm_done),
    .r     (mm_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      modulus       <= MODULUS_RESET[MW-1:0];
      kick          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      kick <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        modulus <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ex        <= s_axis_tdata[BASE_WIDTH +: EW];
            bits_left <= BW'(EW);
            if (modulus == '0) begin
              acc   <= '0;
              state <= S_OUT;
            end else begin
              acc   <= one_mod;
              op_x  <= s_axis_tdata[BASE_WIDTH-1:0];
              op_n  <= CW'(BASE_WIDTH);
              op_y  <= one_mod;
              kick  <= 1'b1;
              state <= S_BASE;
            end
          end
        end
        S_BASE: begin
          if (mm_done) begin
            breg  <= mm_r;
            op_x  <= {acc, {(BASE_WIDTH - MW){1'b0}}};
            op_n  <= CW'(MW);
            op_y  <= acc;
            kick  <= 1'b1;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_done) begin
            acc <= mm_r;
            if (ex[EW-1]) begin
              op_x  <= {mm_r, {(BASE_WIDTH - MW){1'b0}}};
              op_n  <= CW'(MW);
              op_y  <= breg;
              kick  <= 1'b1;
              state <= S_MUL;
            end else begin
              ex        <= ex << 1;
              bits_left <= bits_left - 1'b1;
              if (last_bit) begin
                state <= S_OUT;
              end else begin
                op_x <= {mm_r, {(BASE_WIDTH - MW){1'b0}}};
                op_n <= CW'(MW);
                op_y <= mm_r;
                kick <= 1'b1;
              end
            end
          end
        end
        S_MUL: begin
          if (mm_done) begin
            acc       <= mm_r;
            ex        <= ex << 1;
            bits_left <= bits_left - 1'b1;
            if (last_bit) begin
              state <= S_OUT;
            end else begin
              op_x  <= {mm_r, {(BASE_WIDTH - MW){1'b0}}};
              op_n  <= CW'(MW);
              op_y  <= mm_r;
              kick  <= 1'b1;
              state <= S_SQR;
            end
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tdata  <= OUT_W'(acc);
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && modulus != '0 |-> m_axis_tdata[MW-1:0] < modulus)
    else $error("result not below modulus");

  a_idle_unit_free: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !mm_busy && !kick)
    else $error("multiplier active while taking a request");

  a_done_in_work: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> state == S_BASE || state == S_SQR || state == S_MUL)
    else $error("multiplier result outside a work state");

endmodule
